### design/snfs_pkg.sv
// ----------------------------------------------------------------------------
// snfs_pkg
// Shared widths, word types and sequencer states of the sparse forward solve.
// ----------------------------------------------------------------------------
`default_nettype none

package snfs_pkg;

  localparam int DW        = 32;  // Q16.16 data width
  localparam int NBW       = 11;  // neighbor row field width
  localparam int RIW       = 10;  // emitted row number width
  localparam int ACCW      = 68;  // exact sum of rhs and four products
  localparam int QW        = 64;  // dividend / quotient width
  localparam int MAX_LANES = 4;

  localparam int NEIGHBORS_DEF = 4;
  localparam int ROWS_DEF      = 1024;

  typedef struct packed {
    logic                  start_req;
    logic signed [DW-1:0]  rhs;
    logic signed [DW-1:0]  diag;
    logic signed [DW-1:0]  coef_a;
    logic signed [DW-1:0]  coef_b;
    logic signed [DW-1:0]  coef_c;
    logic signed [DW-1:0]  coef_d;
    logic [NBW-1:0]        nbr_a;
    logic [NBW-1:0]        nbr_b;
    logic [NBW-1:0]        nbr_c;
    logic [NBW-1:0]        nbr_d;
  } in_word_t;

  typedef struct packed {
    logic signed [DW-1:0]  solution;
    logic [RIW-1:0]        row_index;
    logic                  div_error;
  } out_word_t;

  typedef struct packed {
    logic                  busy;
    logic signed [DW-1:0]  res;
    logic                  err;
  } div_stat_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_LAST,
    ST_SUM,
    ST_DSTART,
    ST_DIV
  } state_t;

endpackage

`default_nettype wire

### design/snfs_lane.sv
// ----------------------------------------------------------------------------
// snfs_lane
// One neighbor lane: decides use, forms the read address, multiplies.
// ----------------------------------------------------------------------------
`default_nettype none

module snfs_lane
  import snfs_pkg::*;
#(
  parameter int POS = 1,
  parameter int AW  = 10
) (
  input  wire logic                  clk,
  input  wire logic                  ld,
  input  wire logic signed [DW-1:0]  coef,
  input  wire logic [NBW-1:0]        nbr,
  input  wire logic [AW-1:0]         row,
  input  wire logic signed [DW-1:0]  rd_data,
  output logic [AW-1:0]              addr,
  output logic signed [2*DW-1:0]     prod
);

  localparam int CW = ((AW > NBW) ? AW : NBW) + 1;
  localparam logic signed [2*DW-1:0] PROD_ZERO = '0;

  logic [CW-1:0]           nbr_w;
  logic [CW-1:0]           row_w;
  logic                    use_c;
  logic signed [2*DW-1:0]  prod_r;

  // check position, empty slot and causality
  assign nbr_w = CW'(nbr);
  assign row_w = CW'(row);
  assign use_c = (CW'(POS) <= row_w) && (nbr != '0) && ((nbr_w - CW'(1)) < row_w);
  assign addr  = AW'(nbr_w - CW'(1));

  // multiply the stored value, or drop the lane
  always_ff @(posedge clk) begin
    if (ld) begin
      prod_r <= use_c ? (coef * rd_data) : PROD_ZERO;
    end
  end

  assign prod = prod_r;

endmodule

`default_nettype wire

### design/snfs_div.sv
// ----------------------------------------------------------------------------
// snfs_div
// Bit-serial signed divide of the exact sum by the diagonal, with saturation.
// ----------------------------------------------------------------------------
`default_nettype none

module snfs_div
  import snfs_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    start,
  input  wire logic signed [ACCW-1:0]  acc,
  input  wire logic signed [DW-1:0]    diag,
  output div_stat_t                    stat
);

  localparam logic signed [DW-1:0] SMAX = {1'b0, {(DW-1){1'b1}}};
  localparam logic signed [DW-1:0] SMIN = {1'b1, {(DW-1){1'b0}}};

  logic                    busy_r, busy_nxt;
  logic                    spec_r;
  logic [6:0]              cnt_r;
  logic [DW-1:0]           rem_r;
  logic [QW-1:0]           q_r;
  logic [DW-1:0]           dmag_r;
  logic                    qsgn_r;
  logic signed [DW-1:0]    res_r;
  logic                    err_r;

  logic                    fits;
  logic                    neg;
  logic [QW-1:0]           mag;
  logic [DW:0]             sh;
  logic [DW:0]             diff;
  logic                    ge;
  logic [QW-1:0]           q_nxt;
  logic                    last;

  // classify the dividend
  assign fits = (&acc[ACCW-1:QW-1]) || !(|acc[ACCW-1:QW-1]);
  assign neg  = acc[ACCW-1];
  assign mag  = neg ? (~acc[QW-1:0] + QW'(1)) : acc[QW-1:0];

  // one restoring step
  assign sh    = {rem_r, q_r[QW-1]};
  assign diff  = sh - {1'b0, dmag_r};
  assign ge    = !diff[DW];
  assign q_nxt = {q_r[QW-2:0], ge};
  assign last  = (cnt_r == 7'(QW-1));

  assign busy_nxt = start ? 1'b1 : (busy_r && !(spec_r || last));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
  end

  // load, step and finish
  always_ff @(posedge clk) begin
    if (start) begin
      cnt_r  <= '0;
      rem_r  <= '0;
      q_r    <= mag;
      dmag_r <= diag[DW-1] ? (~diag + DW'(1)) : diag;
      qsgn_r <= neg ^ diag[DW-1];
      spec_r <= (diag == '0) || !fits;
      err_r  <= (diag == '0) || !fits;
      if (diag == '0) begin
        res_r <= neg ? SMIN : ((acc == '0) ? '0 : SMAX);
      end else begin
        res_r <= (neg != diag[DW-1]) ? SMIN : SMAX;
      end
    end else if (busy_r && !spec_r) begin
      cnt_r <= cnt_r + 7'd1;
      rem_r <= ge ? diff[DW-1:0] : sh[DW-1:0];
      q_r   <= q_nxt;
      if (last) begin
        if (qsgn_r && (q_nxt != '0)) begin
          if (q_nxt > QW'(64'h8000_0000)) begin
            res_r <= SMIN;
            err_r <= 1'b1;
          end else begin
            res_r <= DW'(~q_nxt + QW'(1));
            err_r <= 1'b0;
          end
        end else begin
          if (q_nxt > QW'(64'h7FFF_FFFF)) begin
            res_r <= SMAX;
            err_r <= 1'b1;
          end else begin
            res_r <= q_nxt[DW-1:0];
            err_r <= 1'b0;
          end
        end
      end
    end
  end

  assign stat.busy = busy_r;
  assign stat.res  = res_r;
  assign stat.err  = err_r;

endmodule

`default_nettype wire

### design/sparse_neighbor_forward_solve.sv
// ----------------------------------------------------------------------------
// sparse_neighbor_forward_solve
// Sparse lower-triangular forward solve in Q16.16, one row per word.
// ----------------------------------------------------------------------------
// Usage: each input word carries one row (rhs, diagonal, up to NEIGHBORS
// coefficient / 1-based neighbor pairs, start_req). The block subtracts the
// neighbor products from rhs, divides by the diagonal, stores the row's
// solution and sends one output word with solution, row_index, div_error.
// A word with start_req set is row zero; after row ROWS-1 the count wraps.
// One word at a time: a new input word is accepted only after the previous
// one is delivered. Each word takes one solution-memory read per lane, then
// the bit-serial divider, which retires one quotient bit per cycle over 64.
// The output sits in a register: a stalled receiver holds the word there;
// the next input word is taken meanwhile and waits at its end only if the
// previous word has still not been taken.
// Reset: row count returns to zero, no word is pending. Solution memory is
// not cleared; rows are written in order before they are read.
// ----------------------------------------------------------------------------
`default_nettype none

module sparse_neighbor_forward_solve
  import snfs_pkg::*;
#(
  parameter int NEIGHBORS = NEIGHBORS_DEF,
  parameter int ROWS      = ROWS_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_word_t  in_data,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_word_t      out_data
);

  localparam int AW = $clog2(ROWS);
  localparam int LW = (NEIGHBORS > 1) ? $clog2(NEIGHBORS) : 1;

  state_t                  state_r, state_nxt;
  in_word_t                item_r;
  logic [AW-1:0]           row_r;
  logic [AW-1:0]           row_cnt_r;
  logic [LW-1:0]           k_r, k_nxt;
  logic                    ld_vld_r;
  logic [LW-1:0]           ld_idx_r;
  logic signed [ACCW-1:0]  acc_r;
  logic signed [ACCW-1:0]  acc_c;
  logic                    out_valid_r;
  out_word_t               out_r;
  logic                    accept;
  logic                    deliver;
  logic                    div_start;
  div_stat_t               div_stat;

  logic signed [DW-1:0]    mem [ROWS];
  logic signed [DW-1:0]    rd_r;
  logic [AW-1:0]           rd_addr;

  logic signed [DW-1:0]    coef_v [MAX_LANES];
  logic [NBW-1:0]          nbr_v  [MAX_LANES];
  logic [AW-1:0]           addr_v [NEIGHBORS];
  logic signed [2*DW-1:0]  prod_v [NEIGHBORS];

  assign coef_v[0] = item_r.coef_a;
  assign coef_v[1] = item_r.coef_b;
  assign coef_v[2] = item_r.coef_c;
  assign coef_v[3] = item_r.coef_d;
  assign nbr_v[0]  = item_r.nbr_a;
  assign nbr_v[1]  = item_r.nbr_b;
  assign nbr_v[2]  = item_r.nbr_c;
  assign nbr_v[3]  = item_r.nbr_d;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != ST_IDLE);

  // solution memory: write on delivery, read one lane address a cycle
  assign rd_addr = addr_v[k_r];

  always_ff @(posedge clk) begin
    if (deliver) begin
      mem[row_r] <= div_stat.res;
    end
    rd_r <= mem[rd_addr];
  end

  // neighbor lanes
  for (genvar g = 0; g < NEIGHBORS; g++) begin : g_lane
    snfs_lane #(
      .POS (g + 1),
      .AW  (AW)
    ) u_lane (
      .clk     (clk),
      .ld      (ld_vld_r && (ld_idx_r == LW'(g))),
      .coef    (coef_v[g]),
      .nbr     (nbr_v[g]),
      .row     (row_r),
      .rd_data (rd_r),
      .addr    (addr_v[g]),
      .prod    (prod_v[g])
    );
  end

  // merge: rhs in Q32.32 minus all lane products
  always_comb begin
    acc_c = {{(ACCW-DW-16){item_r.rhs[DW-1]}}, item_r.rhs, 16'h0000};
    for (int i = 0; i < NEIGHBORS; i++) begin
      acc_c = acc_c - {{(ACCW-2*DW){prod_v[i][2*DW-1]}}, prod_v[i]};
    end
  end

  snfs_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .acc   (acc_r),
    .diag  (item_r.diag),
    .stat  (div_stat)
  );

  // sequencer next state
  always_comb begin
    state_nxt = state_r;
    k_nxt     = k_r;
    div_start = 1'b0;
    deliver   = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        k_nxt = '0;
        if (accept) begin
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        if (k_r == LW'(NEIGHBORS - 1)) begin
          state_nxt = ST_LAST;
        end else begin
          k_nxt = k_r + LW'(1);
        end
      end
      ST_LAST: begin
        state_nxt = ST_SUM;
      end
      ST_SUM: begin
        state_nxt = ST_DSTART;
      end
      ST_DSTART: begin
        div_start = 1'b1;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (!div_stat.busy && (!out_valid_r || !out_stall)) begin
          deliver   = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      k_r         <= '0;
      ld_vld_r    <= 1'b0;
      row_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      k_r      <= k_nxt;
      ld_vld_r <= (state_r == ST_READ);
      if (accept) begin
        if (in_data.start_req || (row_cnt_r == AW'(ROWS - 1))) begin
          row_cnt_r <= in_data.start_req ? AW'(1) : '0;
        end else begin
          row_cnt_r <= row_cnt_r + AW'(1);
        end
      end
      if (deliver) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    ld_idx_r <= k_r;
    if (accept) begin
      item_r <= in_data;
      row_r  <= in_data.start_req ? '0 : row_cnt_r;
    end
    if (state_r == ST_SUM) begin
      acc_r <= acc_c;
    end
    if (deliver) begin
      out_r.solution  <= div_stat.res;
      out_r.row_index <= RIW'(row_r);
      out_r.div_error <= div_stat.err;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef SYNTHESIS
  // divider only runs while a word is being solved
  a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !(state_r == ST_IDLE && div_stat.busy))
    else $error("divider busy while sequencer idle");

  // one word at a time: an accepted word blocks the next cycle
  a_one_word: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> in_stall)
    else $error("input taken while a word is in progress");

  // delivery never overwrites a word the receiver has not taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    deliver |-> (!out_valid_r || !out_stall))
    else $error("output word overwritten");
`endif

endmodule

`default_nettype wire

### verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the sparse lower-triangular forward solve.
// Each row word is predicted in the bench's own solver, which keeps its own
// table of solved values, and every output word is compared field by field
// in order. Both sides idle in random bursts, and the receiver holds off
// for a long stretch once so that the block fills up and stalls its input.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;
  import snfs_pkg::*;

  localparam int ROWS      = ROWS_DEF;
  localparam int NEIGHBORS = NEIGHBORS_DEF;
  localparam int WDOG_MAX  = 20000;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_word_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_word_t out_data;

  // solver model state
  logic signed [DW-1:0] sol_table [ROWS];
  int unsigned          row_count = 0;
  out_word_t            sol_queue [$];

  int  fail_count = 0;
  int  wdog = 0;
  bit  idle_en = 1'b1;
  bit  hold_req = 1'b0;

  sparse_neighbor_forward_solve u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always #6 clk = ~clk;

  // Predict one row: exact wide sum, truncating divide, saturate.
  function automatic out_word_t solve_row(in_word_t w);
    out_word_t            r;
    logic signed [95:0]   acc;
    logic signed [95:0]   q;
    logic signed [DW-1:0] cf [4];
    logic [NBW-1:0]       nb [4];
    int unsigned          row;
    begin
      if (w.start_req) row_count = 0;
      row = row_count % ROWS;
      cf = '{w.coef_a, w.coef_b, w.coef_c, w.coef_d};
      nb = '{w.nbr_a, w.nbr_b, w.nbr_c, w.nbr_d};
      acc = 96'(w.rhs) <<< 16;
      for (int p = 1; p <= NEIGHBORS; p++) begin
        if (p <= row && nb[p-1] != 0 && nb[p-1] - 1 < row)
          acc = acc - 96'(cf[p-1]) * 96'(sol_table[nb[p-1]-1]);
      end
      r.div_error = 1'b0;
      if (w.diag == 0) begin
        r.div_error = 1'b1;
        r.solution = (acc < 0) ? 32'sh80000000 : (acc == 0) ? 32'sd0 : 32'sh7fffffff;
      end else begin
        q = acc / 96'(w.diag);
        if (q > 96'sh7fffffff) begin
          r.div_error = 1'b1;
          r.solution = 32'sh7fffffff;
        end else if (q < -96'sh80000000) begin
          r.div_error = 1'b1;
          r.solution = 32'sh80000000;
        end else begin
          r.solution = q[DW-1:0];
        end
      end
      sol_table[row] = r.solution;
      r.row_index = row[RIW-1:0];
      row_count = (row + 1) % ROWS;
      return r;
    end
  endfunction

  // Send one word, with an optional random gap before it; valid stays up
  // between back-to-back words.
  task automatic send_word(in_word_t w);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_data  <= w;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sol_queue.push_back(solve_row(w));
  endtask

  // Random value; small fixed-point values mostly, full range sometimes.
  function automatic logic signed [DW-1:0] rand_val();
    case ($urandom_range(0, 4))
      0:       return $urandom;
      1:       return $signed($urandom_range(0, 32'h3ffff)) - 32'sh20000;
      default: return $signed($urandom_range(0, 32'h1ffff)) - 32'sh10000;
    endcase
  endfunction

  function automatic in_word_t rand_word(bit start, int unsigned row);
    in_word_t w;
    begin
      w = '0;
      w.start_req = start;
      w.rhs = rand_val();
      w.diag = ($urandom_range(0, 30) == 0) ? 32'sd0 : rand_val();
      if (w.diag == 0 && $urandom_range(0, 30) != 0) w.diag = 32'sh10000;
      w.coef_a = rand_val(); w.coef_b = rand_val();
      w.coef_c = rand_val(); w.coef_d = rand_val();
      // neighbors mostly at earlier rows, sometimes noise across the field
      w.nbr_a = ($urandom_range(0, 7) == 0) ? NBW'($urandom) : NBW'($urandom_range(0, row));
      w.nbr_b = ($urandom_range(0, 7) == 0) ? NBW'($urandom) : NBW'($urandom_range(0, row));
      w.nbr_c = ($urandom_range(0, 7) == 0) ? NBW'($urandom) : NBW'($urandom_range(0, row));
      w.nbr_d = ($urandom_range(0, 7) == 0) ? NBW'($urandom) : NBW'($urandom_range(0, row));
      return w;
    end
  endfunction

  // Receiver stall: random bursts, or one long hold-off on request.
  always @(posedge clk) begin
    if (hold_req) begin
      out_stall <= 1'b1;
    end else if (idle_en && $urandom_range(0, 5) == 0) begin
      out_stall <= 1'b1;
    end else if (out_stall && idle_en && $urandom_range(0, 2) != 0) begin
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Check each output word against the oldest prediction.
  always @(posedge clk) begin
    out_word_t exp_w;
    if (rst_n && out_valid && !out_stall) begin
      if (sol_queue.size() == 0) begin
        $display("%0t: unexpected word, actual %h", $time, out_data);
        fail_count++;
      end else begin
        exp_w = sol_queue.pop_front();
        if (out_data.solution !== exp_w.solution) begin
          $display("%0t: solution expected %h actual %h", $time,
                   exp_w.solution, out_data.solution);
          fail_count++;
        end
        if (out_data.row_index !== exp_w.row_index) begin
          $display("%0t: row_index expected %0d actual %0d", $time,
                   exp_w.row_index, out_data.row_index);
          fail_count++;
        end
        if (out_data.div_error !== exp_w.div_error) begin
          $display("%0t: div_error expected %b actual %b", $time,
                   exp_w.div_error, out_data.div_error);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: count cycles with no accepted word on either side.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) wdog <= 0;
    else wdog <= wdog + 1;
    if (wdog >= WDOG_MAX) begin
      $display("sparse_neighbor_forward_solve test failed");
      $finish;
    end
  end

  // Extremes, zero diagonal, saturation and lane skipping.
  task automatic test_directed();
    in_word_t w;
    w = '0; w.start_req = 1'b1; w.rhs = 32'sh10000; w.diag = 32'sh10000;
    w.nbr_a = 11'd1; w.coef_a = 32'sh7fffffff;
    send_word(w);                             // row 0: lanes all skipped
    w = '0; w.rhs = 32'sh7fffffff; w.diag = 32'sd0;
    send_word(w);                             // zero diagonal, positive sum
    w = '0; w.rhs = 32'sh80000000; w.diag = 32'sd0;
    send_word(w);                             // zero diagonal, negative sum
    w = '0; w.diag = 32'sd0;
    send_word(w);                             // zero diagonal, zero sum
    w = '0; w.rhs = 32'sh7fffffff; w.diag = 32'sd1;
    send_word(w);                             // overflow high
    w = '0; w.rhs = 32'sh80000000; w.diag = 32'sd1;
    send_word(w);                             // overflow low
    w = '0; w.rhs = 32'sh80000000; w.diag = 32'sh80000000;
    send_word(w);
    w = '0; w.rhs = 32'sh7fffffff; w.diag = 32'sh7fffffff;
    w.coef_a = 32'sh80000000; w.coef_b = 32'sh7fffffff;
    w.coef_c = 32'sh80000000; w.coef_d = 32'sh7fffffff;
    w.nbr_a = 11'd1; w.nbr_b = 11'd2; w.nbr_c = 11'd5; w.nbr_d = 11'd6;
    send_word(w);
    w.nbr_a = 11'd9; w.nbr_b = 11'h7ff; w.nbr_c = 11'd0; w.nbr_d = 11'd1024;
    send_word(w);                             // current, later, none, far rows
    w = '0; w.rhs = -32'sh30000; w.diag = -32'sh20000;
    w.coef_a = 32'sh8000; w.nbr_a = 11'd8; w.coef_d = -32'sh1; w.nbr_d = 11'd3;
    send_word(w);
    w = '0; w.start_req = 1'b1; w.rhs = -32'sh1; w.diag = 32'sh7fffffff;
    w.nbr_a = 11'd1;
    send_word(w);                             // restart in mid-solve
  endtask

  // Random solves of random length, with occasional restarts.
  task automatic test_random(int unsigned n_items);
    int unsigned row;
    bit st;
    row = row_count;
    for (int i = 0; i < n_items; i++) begin
      st = ($urandom_range(0, 40) == 0);
      if (st) row = 0;
      send_word(rand_word(st, row));
      row = row_count;
    end
  endtask

  // Run past row ROWS-1 to see the row count wrap.
  task automatic test_wrap();
    send_word(rand_word(1'b1, 0));
    for (int i = 1; i < ROWS + 4; i++) begin
      if (i % 128 == 0) idle_en = 1'b0;
      else if (i % 128 == 8) idle_en = 1'b1;
      send_word(rand_word(1'b0, (i % ROWS < 4) ? i % ROWS : 4));
    end
  endtask

  // Hold the receiver off while the sender keeps offering words.
  task automatic test_backpressure();
    fork
      begin
        hold_req = 1'b1;
        repeat (600) @(posedge clk);
        hold_req = 1'b0;
      end
      test_random(12);
    join
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_backpressure();
    test_random(30);
    test_wrap();
    // last part runs with no idling
    idle_en = 1'b0;
    test_random(40);
    in_valid <= 1'b0;
    while (sol_queue.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (fail_count == 0) begin
      $display("sparse_neighbor_forward_solve test passed");
    end else begin
      $display("sparse_neighbor_forward_solve test failed");
    end
    $finish;
  end

endmodule
